// File: hw/rtl/b2nd_pkg.sv
`default_nettype none
package b2nd_pkg;

   localparam int MAX_SYM_BITS = 6;
   localparam int QUEUE_DEPTH = 4;
   localparam int GROUP_W = 40;
   localparam int CNT_W = 6;
   localparam int ITEMS_W = 3;

   localparam logic [2:0] ST_BYTE = 3'd0;
   localparam logic [2:0] ST_OK = 3'd1;
   localparam logic [2:0] ST_INVALID = 3'd2;
   localparam logic [2:0] ST_EXCESS_PAD = 3'd3;
   localparam logic [2:0] ST_AFTER_PAD = 3'd4;
   localparam logic [2:0] ST_UNUSED = 3'd5;
   localparam logic [2:0] ST_MISSING_PAD = 3'd6;

   localparam logic [3:0] ALPH_BIN = 4'd0;
   localparam logic [3:0] ALPH_OCT = 4'd1;
   localparam logic [3:0] ALPH_HEX = 4'd2;
   localparam logic [3:0] ALPH_HEX_UC = 4'd3;
   localparam logic [3:0] ALPH_B32HEX = 4'd4;
   localparam logic [3:0] ALPH_B32HEX_UC = 4'd5;
   localparam logic [3:0] ALPH_B32 = 4'd6;
   localparam logic [3:0] ALPH_B32_UC = 4'd7;
   localparam logic [3:0] ALPH_ZB32 = 4'd8;
   localparam logic [3:0] ALPH_B64 = 4'd9;
   localparam logic [3:0] ALPH_B64URL = 4'd10;

   localparam logic [1:0] CSR_ALPHABET_SEL = 2'd0;
   localparam logic [1:0] CSR_PAD_ENABLE = 2'd1;

   typedef struct packed {
      logic [GROUP_W-1:0] group;
      logic [ITEMS_W-1:0] items;
      logic               is_end;
      logic [2:0]         status;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [2:0] sym_bits(input logic [3:0] sel);
      logic [2:0] b;
      case (sel)
         ALPH_BIN: b = 3'd1;
         ALPH_OCT: b = 3'd3;
         ALPH_HEX, ALPH_HEX_UC: b = 3'd4;
         ALPH_B32HEX, ALPH_B32HEX_UC, ALPH_B32, ALPH_B32_UC, ALPH_ZB32: b = 3'd5;
         ALPH_B64, ALPH_B64URL: b = 3'd6;
         default: b = 3'd0;
      endcase
      return b;
   endfunction

   function automatic logic [CNT_W-1:0] grp_bits(input logic [3:0] sel);
      logic [CNT_W-1:0] g;
      case (sel)
         ALPH_BIN, ALPH_HEX, ALPH_HEX_UC: g = 6'd8;
         ALPH_OCT, ALPH_B64, ALPH_B64URL: g = 6'd24;
         ALPH_B32HEX, ALPH_B32HEX_UC, ALPH_B32, ALPH_B32_UC, ALPH_ZB32: g = 6'd40;
         default: g = 6'd0;
      endcase
      return g;
   endfunction

   function automatic logic [7:0] zb32_lookup(input logic [7:0] ch);
      logic [7:0] r;
      case (ch)
         "y": r = 8'd0;   "b": r = 8'd1;   "n": r = 8'd2;   "d": r = 8'd3;
         "r": r = 8'd4;   "f": r = 8'd5;   "g": r = 8'd6;   "8": r = 8'd7;
         "e": r = 8'd8;   "j": r = 8'd9;   "k": r = 8'd10;  "m": r = 8'd11;
         "c": r = 8'd12;  "p": r = 8'd13;  "q": r = 8'd14;  "x": r = 8'd15;
         "o": r = 8'd16;  "t": r = 8'd17;  "1": r = 8'd18;  "u": r = 8'd19;
         "w": r = 8'd20;  "i": r = 8'd21;  "s": r = 8'd22;  "z": r = 8'd23;
         "a": r = 8'd24;  "3": r = 8'd25;  "4": r = 8'd26;  "5": r = 8'd27;
         "h": r = 8'd28;  "7": r = 8'd29;  "6": r = 8'd30;  "9": r = 8'd31;
         default: r = 8'hff;
      endcase
      return r;
   endfunction

   // {hit, value}
   function automatic logic [MAX_SYM_BITS:0] char_lookup(input logic [3:0] sel,
                                                         input logic [7:0] ch);
      logic       ok;
      logic [7:0] v;
      logic       dig, lc, uc;
      ok = 1'b0;
      v = '0;
      dig = (ch >= "0") && (ch <= "9");
      lc = (ch >= "a") && (ch <= "z");
      uc = (ch >= "A") && (ch <= "Z");
      case (sel)
         ALPH_BIN: begin
            if (ch == "0" || ch == "1") begin
               ok = 1'b1; v = ch - "0";
            end
         end
         ALPH_OCT: begin
            if (ch >= "0" && ch <= "7") begin
               ok = 1'b1; v = ch - "0";
            end
         end
         ALPH_HEX, ALPH_B32HEX: begin
            if (dig) begin
               ok = 1'b1; v = ch - "0";
            end else if (ch >= "a" && ((sel == ALPH_HEX && ch <= "f") ||
                                       (sel == ALPH_B32HEX && ch <= "v"))) begin
               ok = 1'b1; v = 8'(ch - "a") + 8'd10;
            end
         end
         ALPH_HEX_UC, ALPH_B32HEX_UC: begin
            if (dig) begin
               ok = 1'b1; v = ch - "0";
            end else if (ch >= "A" && ((sel == ALPH_HEX_UC && ch <= "F") ||
                                       (sel == ALPH_B32HEX_UC && ch <= "V"))) begin
               ok = 1'b1; v = 8'(ch - "A") + 8'd10;
            end
         end
         ALPH_B32: begin
            if (lc) begin
               ok = 1'b1; v = ch - "a";
            end else if (ch >= "2" && ch <= "7") begin
               ok = 1'b1; v = 8'(ch - "2") + 8'd26;
            end
         end
         ALPH_B32_UC: begin
            if (uc) begin
               ok = 1'b1; v = ch - "A";
            end else if (ch >= "2" && ch <= "7") begin
               ok = 1'b1; v = 8'(ch - "2") + 8'd26;
            end
         end
         ALPH_ZB32: begin
            v = zb32_lookup(ch);
            ok = (v != 8'hff);
         end
         ALPH_B64, ALPH_B64URL: begin
            if (uc) begin
               ok = 1'b1; v = ch - "A";
            end else if (lc) begin
               ok = 1'b1; v = 8'(ch - "a") + 8'd26;
            end else if (dig) begin
               ok = 1'b1; v = 8'(ch - "0") + 8'd52;
            end else if ((sel == ALPH_B64 && ch == "+") ||
                         (sel == ALPH_B64URL && ch == "-")) begin
               ok = 1'b1; v = 8'd62;
            end else if ((sel == ALPH_B64 && ch == "/") ||
                         (sel == ALPH_B64URL && ch == "_")) begin
               ok = 1'b1; v = 8'd63;
            end
         end
         default: begin
            ok = 1'b0;
            v = '0;
         end
      endcase
      return {ok, v[MAX_SYM_BITS-1:0]};
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/b2nd_front.sv
`default_nettype none
module b2nd_front import b2nd_pkg::*; #(
   parameter int MAX_BITS_PER_SYMBOL = MAX_SYM_BITS
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic             req_cmd,
   input  wire logic [7:0]       req_symbol,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [1:0]       csr_index,
   input  wire logic [3:0]       csr_wdata,
   input  wire queue_status_type q_status,
   output logic                  push,
   output entry_type             push_entry
);

   logic [3:0]         sel_ff, sel_in;
   logic               pad_en_ff, pad_en_in;
   logic [GROUP_W-1:0] group_ff, group_in;
   logic [CNT_W-1:0]   gbc_ff, gbc_in;
   logic [CNT_W-1:0]   dbc_ff, dbc_in;
   logic               pad_seen_ff, pad_seen_in;
   logic [2:0]         err_ff, err_in;

   logic [2:0]               b;
   logic [CNT_W-1:0]         g;
   logic                     usable;
   logic [MAX_SYM_BITS:0]    lk;
   logic [MAX_BITS_PER_SYMBOL-1:0] sym_val;
   logic                     is_pad;
   logic [GROUP_W-1:0]       grp_n;
   logic [CNT_W-1:0]         gbc_n, dbc_n;
   logic [2:0]               err_end;
   logic [ITEMS_W-1:0]       nbytes_end;
   logic                     accept, csr_wr;

   assign csr_ready = 1'b1;
   assign req_stall = q_status.full;
   assign accept = req_valid && !req_stall;
   assign csr_wr = csr_valid && csr_ready;

   assign b = sym_bits(sel_ff);
   assign g = grp_bits(sel_ff);
   assign usable = (sel_ff <= ALPH_B64URL) && (int'(b) <= MAX_BITS_PER_SYMBOL);
   assign lk = char_lookup(sel_ff, req_symbol);
   assign sym_val = lk[MAX_BITS_PER_SYMBOL-1:0];
   assign is_pad = pad_en_ff && (req_symbol == "=");
   assign grp_n = (group_ff << b) | (is_pad ? '0 : GROUP_W'(sym_val));
   assign gbc_n = gbc_ff + CNT_W'(b);
   assign dbc_n = dbc_ff + (is_pad ? '0 : CNT_W'(b));

   always_comb begin
      err_end = err_ff;
      nbytes_end = '0;
      if (err_ff == ST_BYTE && gbc_ff != '0) begin
         if (pad_en_ff) begin
            err_end = ST_MISSING_PAD;
         end else if (dbc_ff[2:0] >= b) begin
            err_end = ST_UNUSED;
         end else begin
            nbytes_end = dbc_ff[5:3];
         end
      end
   end

   always_comb begin
      sel_in = sel_ff;
      pad_en_in = pad_en_ff;
      group_in = group_ff;
      gbc_in = gbc_ff;
      dbc_in = dbc_ff;
      pad_seen_in = pad_seen_ff;
      err_in = err_ff;
      push = 1'b0;
      push_entry = '0;
      if (csr_wr && (csr_index == CSR_ALPHABET_SEL || csr_index == CSR_PAD_ENABLE)) begin
         if (csr_index == CSR_ALPHABET_SEL) begin
            sel_in = csr_wdata;
         end else begin
            pad_en_in = csr_wdata[0];
         end
         group_in = '0;
         gbc_in = '0;
         dbc_in = '0;
         pad_seen_in = 1'b0;
         err_in = ST_BYTE;
      end else if (accept && !req_cmd) begin
         if (err_ff == ST_BYTE) begin
            if (!usable) begin
               err_in = ST_INVALID;
            end else if (is_pad && dbc_ff == '0) begin
               err_in = ST_EXCESS_PAD;
            end else if (!is_pad && !lk[MAX_SYM_BITS]) begin
               err_in = ST_INVALID;
            end else if (!is_pad && pad_seen_ff) begin
               err_in = ST_AFTER_PAD;
            end else begin
               pad_seen_in = pad_seen_ff | is_pad;
               if (gbc_n >= g) begin
                  group_in = '0;
                  gbc_in = '0;
                  dbc_in = '0;
                  if (dbc_n[2:0] >= b) begin
                     err_in = ST_UNUSED;
                  end else if (dbc_n[5:3] != '0) begin
                     push = 1'b1;
                     push_entry.group = grp_n << (CNT_W'(GROUP_W) - gbc_n);
                     push_entry.items = dbc_n[5:3];
                     push_entry.is_end = 1'b0;
                     push_entry.status = ST_BYTE;
                  end
               end else begin
                  group_in = grp_n;
                  gbc_in = gbc_n;
                  dbc_in = dbc_n;
               end
            end
         end
      end else if (accept) begin
         // end of string: zero-fill, flush and report
         push = 1'b1;
         push_entry.group = group_ff << (CNT_W'(GROUP_W) - gbc_ff);
         push_entry.items = nbytes_end + ITEMS_W'(1);
         push_entry.is_end = 1'b1;
         push_entry.status = (err_end != ST_BYTE) ? err_end : ST_OK;
         group_in = '0;
         gbc_in = '0;
         dbc_in = '0;
         pad_seen_in = 1'b0;
         err_in = ST_BYTE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= ALPH_B64;
         pad_en_ff <= 1'b0;
         group_ff <= '0;
         gbc_ff <= '0;
         dbc_ff <= '0;
         pad_seen_ff <= 1'b0;
         err_ff <= ST_BYTE;
      end else begin
         sel_ff <= sel_in;
         pad_en_ff <= pad_en_in;
         group_ff <= group_in;
         gbc_ff <= gbc_in;
         dbc_ff <= dbc_in;
         pad_seen_ff <= pad_seen_in;
         err_ff <= err_in;
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/b2nd_queue.sv
`default_nettype none
module b2nd_queue import b2nd_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire entry_type  push_entry,
   input  wire logic       pop,
   output entry_type       head,
   output queue_status_type q_status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_QW = $clog2(DEPTH + 1);

   entry_type         slots_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_QW-1:0] count_ff, count_in;

   assign head = slots_ff[rd_ptr_ff];
   assign q_status.full = (count_ff == CNT_QW'(DEPTH));
   assign q_status.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_QW'(push) - CNT_QW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("queue pop while empty");

endmodule
`default_nettype wire

// File: hw/rtl/b2nd_back.sv
`default_nettype none
module b2nd_back import b2nd_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire entry_type        head,
   input  wire queue_status_type q_status,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [7:0]            rsp_data_byte,
   output logic [2:0]            rsp_status,
   output logic                  rsp_last
);

   logic      cur_valid_ff, cur_valid_in;
   entry_type cur_ff, cur_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff, rsp_data_in;
   logic [2:0] rsp_status_ff, rsp_status_in;
   logic       rsp_last_ff, rsp_last_in;

   logic out_free, emit, final_item, status_item;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit = cur_valid_ff && out_free;
   assign final_item = (cur_ff.items == ITEMS_W'(1));
   assign status_item = cur_ff.is_end && final_item;
   assign pop = !q_status.empty && (!cur_valid_ff || (emit && final_item));

   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_in = cur_ff;
      if (pop) begin
         cur_valid_in = 1'b1;
         cur_in = head;
      end else if (emit) begin
         if (final_item) begin
            cur_valid_in = 1'b0;
         end else begin
            cur_in.items = cur_ff.items - ITEMS_W'(1);
            cur_in.group = cur_ff.group << 8;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in = rsp_last_ff;
      if (out_free) begin
         rsp_valid_in = emit;
         if (status_item) begin
            rsp_data_in = 8'h00;
            rsp_status_in = cur_ff.status;
            rsp_last_in = 1'b1;
         end else begin
            rsp_data_in = cur_ff.group[GROUP_W-1 -: 8];
            rsp_status_in = ST_BYTE;
            rsp_last_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      rsp_data_ff <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data_byte = rsp_data_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last = rsp_last_ff;

   a_items_nonzero: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> cur_ff.items != '0)
      else $error("entry in work with no words left");

   a_byte_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_BYTE) |-> !rsp_last_ff)
      else $error("data word flagged as last");

endmodule
`default_nettype wire

// File: hw/rtl/base2n_text_decoder_unit.sv
`default_nettype none
// base2n text decoder
// req channel: one word per item, req_cmd 0 carries a text character in req_symbol,
// req_cmd 1 marks end of string. accepted when req_valid is high and req_stall low.
// rsp channel: decoded bytes (rsp_status 0), then one status word with rsp_last 1
// at each end of string; on an error status the bytes of that string are to be dropped.
// csr channel: csr_index 0 selects the alphabet, 1 enables '=' padding; writes are
// always taken (csr_ready is always high); those to index 0 or 1 restart the string.
// throughput: one req word per cycle while req_stall is low; rsp delivers one word
// per cycle while rsp_stall is low, one per decoded byte. a 4-entry queue between
// the character front end and the byte sequencer absorbs bursts; req_stall rises
// when it is full. group bytes pass a queue slot, the current entry and rsp registers.
// reset: alphabet back to base64, padding off; string state, queue and rsp_valid cleared.
// a stalled rsp word holds; the queue then fills and req_stall follows.
module base2n_text_decoder_unit import b2nd_pkg::*; #(
   parameter int MAX_BITS_PER_SYMBOL = MAX_SYM_BITS,
   parameter int Q_DEPTH = QUEUE_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_cmd,
   input  wire logic [7:0] req_symbol,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_data_byte,
   output logic [2:0]      rsp_status,
   output logic            rsp_last,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [1:0] csr_index,
   input  wire logic [3:0] csr_wdata
);

   logic             push, pop;
   entry_type        push_entry, head;
   queue_status_type q_status;

   b2nd_front #(
      .MAX_BITS_PER_SYMBOL(MAX_BITS_PER_SYMBOL)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_cmd    (req_cmd),
      .req_symbol (req_symbol),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   b2nd_queue #(
      .DEPTH(Q_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .q_status   (q_status)
   );

   b2nd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .q_status      (q_status),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data_byte (rsp_data_byte),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_last)
   );

endmodule
`default_nettype wire
